FILE: hw/rtl/rbfd_pkg.sv
package rbfd_pkg;

  typedef struct packed {
    logic [31:0] hash;
    logic [31:0] source;
    logic [31:0] stamp;
  } entry_t;

  localparam logic [1:0] VERDICT_NONE   = 2'd0;
  localparam logic [1:0] VERDICT_REPEAT = 2'd1;
  localparam logic [1:0] VERDICT_BURST  = 2'd2;

  localparam logic CMD_MESSAGE = 1'b0;
  localparam logic CMD_CLEAR   = 1'b1;

  localparam logic [1:0] REG_WINDOW_SECONDS = 2'd0;
  localparam logic [1:0] REG_MSG_COUNT      = 2'd1;
  localparam logic [1:0] REG_ENABLE         = 2'd2;

  localparam logic [15:0] WINDOW_SECONDS_RST = 16'd60;
  localparam logic [3:0]  MSG_COUNT_RST      = 4'd10;
  localparam logic        ENABLE_RST         = 1'b0;

endpackage

FILE: hw/rtl/repeat_and_burst_flood_detector_top.sv
// Flood detector for one chat channel.
// Items arrive on the in_ stream: tuser carries the command (message or clear),
// tdata carries timestamp, sender id, text hash and the privileged flag.
// Every input item produces exactly one result item on the out_ stream with
// the verdict (none, repeated text, single sender burst) and the fill level.
// Messages are kept in a circular window held in a small memory; after each
// push that needs a check one shared compare unit walks the held entries,
// one per cycle, over the window memory read port, then an evaluation step
// sets the verdict. A clear command, or a message that cannot be flagged,
// goes straight to the output register without a scan.
// The block accepts one item at a time and is ready again once the result
// is loaded into the output register.
// If the receiver stalls, the finished result waits in the output register;
// the block may accept the next item meanwhile but holds its own result
// until the register frees up.
// Reset empties the window and loads the register defaults (60 seconds,
// count 10, disabled). Registers are to be written over the APB port only
// while idle; this is a rule for the user, and the block itself does not
// enforce it.
module repeat_and_burst_flood_detector_top
  import rbfd_pkg::*;
#(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // timestamp, source_id, message_hash, privileged
  input  logic         in_tuser,   // command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata,  // verdict, fill_level
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int MW = (CW > 4) ? CW : 4;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EVAL, S_DONE} state_t;

  state_t        state_r;
  logic [15:0]   window_seconds_r;
  logic [3:0]    msg_count_r;
  logic          enable_r;
  logic [CW-1:0] fill_r;
  logic [AW-1:0] head_r;
  logic [AW-1:0] ptr_r;
  logic [31:0]   stamp_r;
  logic [31:0]   source_r;
  logic [31:0]   hash_r;
  logic [31:0]   oldest_r;
  logic [31:0]   first_r;
  logic          seen_r;
  logic [CW-1:0] iss_cnt_r;
  logic [CW-1:0] acc_cnt_r;
  logic          rd_vld_r;
  logic [CW-1:0] text_cnt_r;
  logic [CW-1:0] user_cnt_r;
  logic [1:0]    verdict_r;
  logic          out_valid_r;
  logic [1:0]    out_verdict_r;
  logic [4:0]    out_fill_r;

  logic          accept;
  logic          cfg_write;
  logic          drop;
  logic [AW-1:0] head_d;
  logic [CW-1:0] fill_d;
  logic [CW-1:0] fill_n;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic          do_check;
  logic          issue;
  entry_t        wr_data;
  entry_t        rd_data;
  logic [31:0]   span;
  logic [31:0]   user_age;
  logic [MW-1:0] half_count;

  function automatic logic [AW-1:0] wrap_idx(input logic [AW:0] a);
    logic [AW:0] r;
    r = a;
    if (a >= (AW+1)'(WINDOW_DEPTH)) begin
      r = a - (AW+1)'(WINDOW_DEPTH);
    end
    return r[AW-1:0];
  endfunction

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_fill_r, out_verdict_r};
  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[3:2])
      REG_WINDOW_SECONDS: prdata = {16'd0, window_seconds_r};
      REG_MSG_COUNT:      prdata = {28'd0, msg_count_r};
      REG_ENABLE:         prdata = {31'd0, enable_r};
      default:            prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_seconds_r <= WINDOW_SECONDS_RST;
      msg_count_r      <= MSG_COUNT_RST;
      enable_r         <= ENABLE_RST;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_WINDOW_SECONDS: window_seconds_r <= pwdata[15:0];
        REG_MSG_COUNT:      msg_count_r      <= pwdata[3:0];
        REG_ENABLE:         enable_r         <= pwdata[0];
        default:            ;
      endcase
    end
  end

  always_comb begin
    drop     = (MW'(fill_r) > MW'(msg_count_r)) || (fill_r >= CW'(WINDOW_DEPTH));
    head_d   = drop ? wrap_idx({1'b0, head_r} + (AW+1)'(1)) : head_r;
    fill_d   = drop ? fill_r - CW'(1) : fill_r;
    fill_n   = fill_d + CW'(1);
    wr_addr  = wrap_idx({1'b0, head_d} + (AW+1)'(fill_d));
    wr_en    = accept && (in_tuser == CMD_MESSAGE);
    do_check = !in_tdata[96] && enable_r && (MW'(fill_n) >= MW'(msg_count_r))
               && (fill_n >= CW'(2));
    wr_data  = '{hash: in_tdata[95:64], source: in_tdata[63:32], stamp: in_tdata[31:0]};
    issue    = (state_r == S_SCAN) && (iss_cnt_r < fill_r);
    span       = stamp_r - oldest_r;
    user_age   = stamp_r - first_r;
    half_count = MW'(msg_count_r >> 1);
  end

  rbfd_store #(
    .DEPTH(WINDOW_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (ptr_r),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      seen_r      <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            stamp_r    <= in_tdata[31:0];
            source_r   <= in_tdata[63:32];
            hash_r     <= in_tdata[95:64];
            iss_cnt_r  <= '0;
            acc_cnt_r  <= '0;
            text_cnt_r <= '0;
            user_cnt_r <= '0;
            seen_r     <= 1'b0;
            rd_vld_r   <= 1'b0;
            verdict_r  <= VERDICT_NONE;
            if (in_tuser == CMD_CLEAR) begin
              fill_r  <= '0;
              state_r <= S_DONE;
            end else begin
              fill_r  <= fill_n;
              head_r  <= head_d;
              ptr_r   <= head_d;
              state_r <= do_check ? S_SCAN : S_DONE;
            end
          end
        end
        S_SCAN: begin
          rd_vld_r <= issue;
          if (issue) begin
            ptr_r     <= wrap_idx({1'b0, ptr_r} + (AW+1)'(1));
            iss_cnt_r <= iss_cnt_r + CW'(1);
          end
          if (rd_vld_r) begin
            if (acc_cnt_r == '0) begin
              oldest_r <= rd_data.stamp;
            end
            if (rd_data.hash == hash_r) begin
              text_cnt_r <= text_cnt_r + CW'(1);
            end
            if (rd_data.source == source_r) begin
              user_cnt_r <= user_cnt_r + CW'(1);
              if (!seen_r) begin
                first_r <= rd_data.stamp;
                seen_r  <= 1'b1;
              end
            end
            acc_cnt_r <= acc_cnt_r + CW'(1);
            if (acc_cnt_r == fill_r - CW'(1)) begin
              state_r <= S_EVAL;
            end
          end
        end
        S_EVAL: begin
          priority if (span > {16'd0, window_seconds_r}) begin
            verdict_r <= VERDICT_NONE;
          end else if (MW'(text_cnt_r) > half_count) begin
            verdict_r <= VERDICT_REPEAT;
          end else if ((MW'(user_cnt_r) > half_count) &&
                       (user_age < {18'd0, window_seconds_r[15:2]})) begin
            verdict_r <= VERDICT_BURST;
          end else begin
            verdict_r <= VERDICT_NONE;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r   <= 1'b1;
            out_verdict_r <= verdict_r;
            out_fill_r    <= 5'(fill_r);
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("block accepted a second item while busy");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(WINDOW_DEPTH))
    else $error("window fill exceeds its depth");

  a_flag_needs_entries: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_verdict_r != VERDICT_NONE) |-> (out_fill_r >= 5'd2))
    else $error("flag raised with fewer than two entries");

  a_flag_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && out_verdict_r != VERDICT_NONE |-> enable_r)
    else $error("flag raised while disabled");

endmodule

FILE: hw/rtl/rbfd_store.sv
module rbfd_store
  import rbfd_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  entry_t                   wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output entry_t                   rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
